### hdl/gwtu_pkg.sv
`timescale 1ns / 1ps
// Constants, types and helper functions shared by the GPS-to-UTC calendar converter.
package gwtu_pkg;

	localparam int PIPE_STAGES = 9;

	localparam logic [29:0] TOW_MAX = 30'd604799999;

	// Divide by 1000 as a shift by three, then a reciprocal multiply for 125.
	localparam logic [27:0] RECIP_125 = 28'd137438954;
	localparam int SHIFT_125 = 34;

	localparam logic [19:0] SECS_PER_DAY = 20'd86400;
	localparam logic [12:0] RECIP_675 = 13'd6214;
	localparam int SHIFT_675 = 22;

	// 1970-01-01 sits at day 3657 before the GPS epoch; one day is lent to absorb leap seconds.
	localparam logic [20:0] CIVIL_DAY_BASE = 21'd723124;

	localparam logic [20:0] ERA_DAYS = 21'd146097;

	localparam logic [12:0] RECIP_225 = 13'd4661;
	localparam int SHIFT_225 = 20;
	localparam logic [10:0] RECIP_15 = 11'd1093;
	localparam int SHIFT_15 = 14;

	localparam logic [15:0] RECIP_365_A = 16'd45965;
	localparam int SHIFT_365_A = 24;
	localparam logic [17:0] RECIP_365_B = 18'd183860;
	localparam int SHIFT_365_B = 26;
	localparam logic [17:0] YEARS4_DAYS = 18'd36524;
	localparam logic [17:0] LAST_ERA_DAY = 18'd146096;

	localparam logic [10:0] RECIP_153 = 11'd1714;
	localparam int SHIFT_153 = 18;

	typedef struct packed {
		logic [PIPE_STAGES-1:0] en;
		logic [PIPE_STAGES-1:0] vld;
	} gwtu_pipe_t;

	// Day of the March-based year on which each month begins.
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0: r = 9'd0;
			4'd1: r = 9'd31;
			4'd2: r = 9'd61;
			4'd3: r = 9'd92;
			4'd4: r = 9'd122;
			4'd5: r = 9'd153;
			4'd6: r = 9'd184;
			4'd7: r = 9'd214;
			4'd8: r = 9'd245;
			4'd9: r = 9'd275;
			4'd10: r = 9'd306;
			4'd11: r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

### hdl/gwtu_if.sv
`timescale 1ns / 1ps
// Request channels for GPS time stamps in and UTC calendar results out.
interface gwtu_stamp_if;
	logic        valid;
	logic        ready;
	logic [15:0] week_number;
	logic [29:0] time_of_week_ms;
	logic [7:0]  leap_second_count;

	modport source(output valid, week_number, time_of_week_ms, leap_second_count, input ready);
	modport sink(input valid, week_number, time_of_week_ms, leap_second_count, output ready);
endinterface

interface gwtu_cal_if;
	logic        valid;
	logic        ready;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day_of_month;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;
	logic [9:0]  millisecond;

	modport source(output valid, year, month, day_of_month, hour, minute, second, millisecond,
		input ready);
	modport sink(input valid, year, month, day_of_month, hour, minute, second, millisecond,
		output ready);
endinterface

### hdl/gwtu_pipe_ctrl.sv
`timescale 1ns / 1ps
// Valid tracking and per-stage load enables for the converter pipeline.
module gwtu_pipe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                out_ready,
	output gwtu_pkg::gwtu_pipe_t ctrl
);

	localparam int N = gwtu_pkg::PIPE_STAGES;

	logic [N-1:0] vld_q;
	logic [N-1:0] en;

	// A stage loads when it is empty or its contents move on in the same cycle.
	always_comb begin
		en[N-1] = ~vld_q[N-1] | out_ready;
		for (int i = N - 2; i >= 0; i--) begin
			en[i] = ~vld_q[i] | en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < N; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign in_ready = en[0];
	assign ctrl     = {en, vld_q};

endmodule

### hdl/gps_week_tow_to_utc_calendar_core.sv
`timescale 1ns / 1ps
// Top level: GPS week and time of week to broken-down UTC calendar date and time.
// An accepted request flows from the stage 1 register to the stage 9 output register.
// One request per cycle unless the output stalls; most stages hold multiplies by constants.
// Output stalls hold full stages with no bubble after them; bubbles fill and no request is lost.
// Reset (arst_n low) empties the pipeline at once; data registers are not reset.
module gps_week_tow_to_utc_calendar_core (
	input  logic          clk,
	input  logic          arst_n,
	gwtu_stamp_if.sink    stamp,
	gwtu_cal_if.source    calendar
);

	gwtu_pkg::gwtu_pipe_t ctrl;

	gwtu_pipe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (stamp.valid),
		.in_ready (stamp.ready),
		.out_ready(calendar.ready),
		.ctrl     (ctrl)
	);

	// Stage 1: saturate and split off whole seconds.
	logic [29:0] tow_sat;
	logic [54:0] sec_prod;
	logic [29:0] tow_s1;
	logic [19:0] tsec_s1;
	logic [7:0]  leap_s1;
	logic [15:0] week_s1;

	assign tow_sat  = (stamp.time_of_week_ms > gwtu_pkg::TOW_MAX) ? gwtu_pkg::TOW_MAX
		: stamp.time_of_week_ms;
	assign sec_prod = 55'(tow_sat[29:3]) * 55'(gwtu_pkg::RECIP_125);

	always_ff @(posedge clk) begin
		if (ctrl.en[0]) begin
			tow_s1  <= tow_sat;
			tsec_s1 <= sec_prod[gwtu_pkg::SHIFT_125 +: 20];
			leap_s1 <= stamp.leap_second_count;
			week_s1 <= stamp.week_number;
		end
	end

	// Stage 2: millisecond remainder, seconds since the day before the week, day of week.
	logic [29:0] tsec_x1000;
	logic [19:0] sow;
	logic [25:0] dayw_prod;
	logic [9:0]  ms_s2;
	logic [19:0] sow_s2;
	logic [2:0]  dayw_s2;
	logic [15:0] week_s2;

	assign tsec_x1000 = {tsec_s1, 10'd0} - {6'd0, tsec_s1, 4'd0} - {7'd0, tsec_s1, 3'd0};
	assign sow        = tsec_s1 + gwtu_pkg::SECS_PER_DAY - 20'(leap_s1);
	assign dayw_prod  = 26'(sow[19:7]) * 26'(gwtu_pkg::RECIP_675);

	always_ff @(posedge clk) begin
		if (ctrl.en[1]) begin
			ms_s2   <= 10'(tow_s1 - tsec_x1000);
			sow_s2  <= sow;
			dayw_s2 <= dayw_prod[gwtu_pkg::SHIFT_675 +: 3];
			week_s2 <= week_s1;
		end
	end

	// Stage 3: time of day and day number shifted to the start of a March-based era.
	logic [19:0] dayw_secs;
	logic [20:0] week_days;
	logic [9:0]  ms_s3;
	logic [16:0] tod_s3;
	logic [20:0] z_s3;

	assign dayw_secs = 20'(dayw_s2) * gwtu_pkg::SECS_PER_DAY;
	assign week_days = {2'd0, week_s2, 3'd0} - {5'd0, week_s2};

	always_ff @(posedge clk) begin
		if (ctrl.en[2]) begin
			ms_s3  <= ms_s2;
			tod_s3 <= 17'(sow_s2 - dayw_secs);
			z_s3   <= week_days + 21'(dayw_s2) + gwtu_pkg::CIVIL_DAY_BASE;
		end
	end

	// Stage 4: 400-year era and day of era; hour of day.
	logic [2:0]  era_cnt;
	logic [3:0]  era;
	logic [20:0] era_base;
	logic [25:0] hr_prod;
	logic [9:0]  ms_s4;
	logic [16:0] tod_s4;
	logic [3:0]  era_s4;
	logic [17:0] doe_s4;
	logic [4:0]  hr_s4;

	// Day numbers here only span eras four to eight.
	always_comb begin
		era_cnt = 3'(z_s3 >= 5 * gwtu_pkg::ERA_DAYS) + 3'(z_s3 >= 6 * gwtu_pkg::ERA_DAYS)
			+ 3'(z_s3 >= 7 * gwtu_pkg::ERA_DAYS) + 3'(z_s3 >= 8 * gwtu_pkg::ERA_DAYS);
		era      = 4'd4 + 4'(era_cnt);
		era_base = 21'(era) * gwtu_pkg::ERA_DAYS;
	end

	assign hr_prod = 26'(tod_s3[16:4]) * 26'(gwtu_pkg::RECIP_225);

	always_ff @(posedge clk) begin
		if (ctrl.en[3]) begin
			ms_s4  <= ms_s3;
			tod_s4 <= tod_s3;
			era_s4 <= era;
			doe_s4 <= 18'(z_s3 - era_base);
			hr_s4  <= hr_prod[gwtu_pkg::SHIFT_225 +: 5];
		end
	end

	// Stage 5: leap-day corrected numerator for the year of era; seconds within the hour.
	logic [31:0] d1460_prod;
	logic [2:0]  c36524;
	logic [17:0] hr_secs;
	logic [9:0]  ms_s5;
	logic [3:0]  era_s5;
	logic [17:0] doe_s5;
	logic [17:0] num_s5;
	logic [4:0]  hr_s5;
	logic [11:0] rem_s5;

	assign d1460_prod = 32'(doe_s4[17:2]) * 32'(gwtu_pkg::RECIP_365_A);
	assign c36524 = 3'(doe_s4 >= gwtu_pkg::YEARS4_DAYS) + 3'(doe_s4 >= 2 * gwtu_pkg::YEARS4_DAYS)
		+ 3'(doe_s4 >= 3 * gwtu_pkg::YEARS4_DAYS) + 3'(doe_s4 >= 4 * gwtu_pkg::YEARS4_DAYS);
	assign hr_secs = 18'(hr_s4) * 18'd3600;

	always_ff @(posedge clk) begin
		if (ctrl.en[4]) begin
			ms_s5  <= ms_s4;
			era_s5 <= era_s4;
			doe_s5 <= doe_s4;
			num_s5 <= doe_s4 - 18'(d1460_prod[gwtu_pkg::SHIFT_365_A +: 8]) + 18'(c36524)
				- 18'(doe_s4 == gwtu_pkg::LAST_ERA_DAY);
			hr_s5  <= hr_s4;
			rem_s5 <= 12'(18'(tod_s4) - hr_secs);
		end
	end

	// Stage 6: year of era; minute of hour.
	logic [35:0] yoe_prod;
	logic [20:0] mn_prod;
	logic [9:0]  ms_s6;
	logic [3:0]  era_s6;
	logic [17:0] doe_s6;
	logic [8:0]  yoe_s6;
	logic [4:0]  hr_s6;
	logic [11:0] rem_s6;
	logic [5:0]  mn_s6;

	assign yoe_prod = 36'(num_s5) * 36'(gwtu_pkg::RECIP_365_B);
	assign mn_prod  = 21'(rem_s5[11:2]) * 21'(gwtu_pkg::RECIP_15);

	always_ff @(posedge clk) begin
		if (ctrl.en[5]) begin
			ms_s6  <= ms_s5;
			era_s6 <= era_s5;
			doe_s6 <= doe_s5;
			yoe_s6 <= yoe_prod[gwtu_pkg::SHIFT_365_B +: 9];
			hr_s6  <= hr_s5;
			rem_s6 <= rem_s5;
			mn_s6  <= mn_prod[gwtu_pkg::SHIFT_15 +: 6];
		end
	end

	// Stage 7: day of the March-based year; second of minute.
	logic [1:0]  c100;
	logic [17:0] year_days;
	logic [9:0]  ms_s7;
	logic [3:0]  era_s7;
	logic [8:0]  yoe_s7;
	logic [8:0]  doy_s7;
	logic [4:0]  hr_s7;
	logic [5:0]  mn_s7;
	logic [5:0]  sec_s7;

	assign c100 = 2'(yoe_s6 >= 9'd100) + 2'(yoe_s6 >= 9'd200) + 2'(yoe_s6 >= 9'd300);
	assign year_days = 18'(yoe_s6) * 18'd365 + 18'(yoe_s6[8:2]) - 18'(c100);

	always_ff @(posedge clk) begin
		if (ctrl.en[6]) begin
			ms_s7  <= ms_s6;
			era_s7 <= era_s6;
			yoe_s7 <= yoe_s6;
			doy_s7 <= 9'(doe_s6 - year_days);
			hr_s7  <= hr_s6;
			mn_s7  <= mn_s6;
			sec_s7 <= 6'(rem_s6 - 12'(mn_s6) * 12'd60);
		end
	end

	// Stage 8: month index counted from March.
	logic [10:0] mp_num;
	logic [21:0] mp_prod;
	logic [9:0]  ms_s8;
	logic [3:0]  era_s8;
	logic [8:0]  yoe_s8;
	logic [8:0]  doy_s8;
	logic [3:0]  mp_s8;
	logic [4:0]  hr_s8;
	logic [5:0]  mn_s8;
	logic [5:0]  sec_s8;

	assign mp_num  = 11'(doy_s7) * 11'd5 + 11'd2;
	assign mp_prod = 22'(mp_num) * 22'(gwtu_pkg::RECIP_153);

	always_ff @(posedge clk) begin
		if (ctrl.en[7]) begin
			ms_s8  <= ms_s7;
			era_s8 <= era_s7;
			yoe_s8 <= yoe_s7;
			doy_s8 <= doy_s7;
			mp_s8  <= mp_prod[gwtu_pkg::SHIFT_153 +: 4];
			hr_s8  <= hr_s7;
			mn_s8  <= mn_s7;
			sec_s8 <= sec_s7;
		end
	end

	// Stage 9: calendar month, day and year; this is the output register.
	logic [3:0]  month;
	logic [11:0] era_years;
	logic [11:0] year_s9;
	logic [3:0]  month_s9;
	logic [4:0]  day_s9;
	logic [4:0]  hr_s9;
	logic [5:0]  mn_s9;
	logic [5:0]  sec_s9;
	logic [9:0]  ms_s9;

	assign month     = (mp_s8 < 4'd10) ? mp_s8 + 4'd3 : mp_s8 - 4'd9;
	assign era_years = {era_s8, 8'd0} + {1'b0, era_s8, 7'd0} + {4'd0, era_s8, 4'd0};

	always_ff @(posedge clk) begin
		if (ctrl.en[8]) begin
			year_s9  <= era_years + 12'(yoe_s8) + 12'(month <= 4'd2);
			month_s9 <= month;
			day_s9   <= 5'(doy_s8 - gwtu_pkg::month_start(mp_s8) + 9'd1);
			hr_s9    <= hr_s8;
			mn_s9    <= mn_s8;
			sec_s9   <= sec_s8;
			ms_s9    <= ms_s8;
		end
	end

	assign calendar.valid        = ctrl.vld[gwtu_pkg::PIPE_STAGES-1];
	assign calendar.year         = year_s9;
	assign calendar.month        = month_s9;
	assign calendar.day_of_month = day_s9;
	assign calendar.hour         = hr_s9;
	assign calendar.minute       = mn_s9;
	assign calendar.second       = sec_s9;
	assign calendar.millisecond  = ms_s9;

endmodule
